### hw/rtl/mpq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and constants for the max priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

    localparam int MPQ_CAPACITY = 16;
    localparam int DATA_W       = 32;
    localparam int OUT_CNT_W    = 5;

    // request kind carried in tuser
    typedef enum logic {
        ACT_ENQ = 1'b0,
        ACT_DEQ = 1'b1
    } t_mpq_action;

    // per-beat command broadcast to every cell
    typedef struct packed {
        logic                     enq;    // accepted enqueue, not full
        logic                     deq;    // accepted dequeue, not empty
        logic signed [DATA_W-1:0] value;  // value to insert
    } t_mpq_ctl;

endpackage
`default_nettype wire

### hw/rtl/mpq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpq_cell
// One slot of the sorted chain. Slots hold values in descending order, the
// largest in slot 0. On insert a slot keeps its value, takes the new value,
// or takes its left neighbor's value; on remove it takes its right neighbor's.
// ----------------------------------------------------------------------------
module mpq_cell (
    input  wire logic                             i_clk,
    input  wire mpq_pkg::t_mpq_ctl                i_ctl,
    input  wire logic                             i_occupied,
    input  wire logic                             i_left_keep,
    input  wire logic signed [mpq_pkg::DATA_W-1:0] i_left_val,
    input  wire logic signed [mpq_pkg::DATA_W-1:0] i_right_val,
    output logic                                  o_keep,
    output logic signed [mpq_pkg::DATA_W-1:0]     o_val,
    output logic signed [mpq_pkg::DATA_W-1:0]     o_next
);
    import mpq_pkg::*;

    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] n_val;

    // keep slot when it holds a strictly larger value than the new one
    assign o_keep = i_occupied && (r_val > i_ctl.value);

    // next slot content
    always_comb begin
        n_val = r_val;
        if (i_ctl.enq) begin
            if (!o_keep) begin
                n_val = i_left_keep ? i_ctl.value : i_left_val;
            end
        end else if (i_ctl.deq) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val  = r_val;
    assign o_next = n_val;

endmodule
`default_nettype wire

### hw/rtl/max_priority_queue_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// max_priority_queue_unit
// Bounded max priority queue built as a chain of sorted slots.
// ----------------------------------------------------------------------------
// Result: registered; a result beat is valid in the cycle after its request beat is accepted.
// Throughput: one request per cycle unless a held result beat stalls the input;
//   every slot shifts or holds in parallel, whatever the fill level.
// Reset: synchronous active-low; clears the count and the output valid.
//   Slot contents are not reset and are only read below the count.
// ----------------------------------------------------------------------------
module max_priority_queue_unit #(
    parameter int CAPACITY = mpq_pkg::MPQ_CAPACITY
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] value
    input  wire logic        s_axis_tuser,   // [0] action
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata    // [31:0] removed_value, [63:32] top_value,
                                             // [68:64] entry_count, [69] is_empty,
                                             // [70] is_full, [71] refused
);
    import mpq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic                     s_fire;
    t_mpq_action              act;
    logic                     is_full_now;
    logic                     is_empty_now;
    t_mpq_ctl                 ctl;

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;

    logic [CAPACITY-1:0]      keep;
    logic [CAPACITY-1:0]      occupied;
    logic signed [DATA_W-1:0] cell_val  [CAPACITY];
    logic signed [DATA_W-1:0] cell_next [CAPACITY];

    logic                     r_ovalid;
    logic [71:0]              r_odata;
    logic [71:0]              n_odata;

    logic signed [DATA_W-1:0] removed;
    logic signed [DATA_W-1:0] top;
    logic                     refused;

    // request decode
    assign s_axis_tready = !r_ovalid || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign act           = t_mpq_action'(s_axis_tuser);
    assign is_full_now   = (r_count == CAP_CNT);
    assign is_empty_now  = (r_count == '0);

    always_comb begin
        ctl.enq   = s_fire && (act == ACT_ENQ) && !is_full_now;
        ctl.deq   = s_fire && (act == ACT_DEQ) && !is_empty_now;
        ctl.value = s_axis_tdata;
    end

    // slot chain
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
        logic                     left_keep;
        logic signed [DATA_W-1:0] left_val;
        logic signed [DATA_W-1:0] right_val;

        assign occupied[i] = IDX < r_count;

        if (i == 0) begin : g_head
            assign left_keep = 1'b1;
            assign left_val  = ctl.value;
        end else begin : g_body
            assign left_keep = keep[i-1];
            assign left_val  = cell_val[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign right_val = '0;
        end else begin : g_mid
            assign right_val = cell_val[i+1];
        end

        mpq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_occupied  (occupied[i]),
            .i_left_keep (left_keep),
            .i_left_val  (left_val),
            .i_right_val (right_val),
            .o_keep      (keep[i]),
            .o_val       (cell_val[i]),
            .o_next      (cell_next[i])
        );
    end

    // count update
    always_comb begin
        n_count = r_count;
        if (ctl.enq) begin
            n_count = r_count + CNT_W'(1);
        end else if (ctl.deq) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // result beat
    always_comb begin
        removed = ctl.deq ? cell_val[0] : '0;
        top     = (n_count == '0) ? '0 : cell_next[0];
        refused = s_fire && !ctl.enq && !ctl.deq;
        n_odata = {refused,
                   (n_count == CAP_CNT),
                   (n_count == '0),
                   OUT_CNT_W'(n_count),
                   top,
                   removed};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (s_fire) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_odata <= n_odata;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

`ifndef SYNTHESIS
    // fill level never passes capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("queue count above capacity");

    // accepted enqueue into a non-full queue grows the count by one
    a_enq_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire && (act == ACT_ENQ) && !is_full_now |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("enqueue did not grow count");

    // dequeue on empty leaves the queue empty
    a_deq_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire && (act == ACT_DEQ) && is_empty_now |=> r_count == '0)
        else $error("dequeue on empty changed count");

    // refused flag in the result beat matches the state it saw
    a_refused_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> r_odata[71] == ($past(act == ACT_ENQ) ? $past(is_full_now)
                                                         : $past(is_empty_now)))
        else $error("refused flag mismatch");

    // occupied slots stay in descending order
    for (genvar k = 0; k < CAPACITY - 1; k++) begin : g_order_chk
        a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            occupied[k+1] |-> cell_val[k] >= cell_val[k+1])
            else $error("slot chain out of order");
    end
`endif

endmodule
`default_nettype wire
